/* rtl/tasr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasr_pkg
// shared types, constants and controller codes of the three-axis servo ramp
// ----------------------------------------------------------------------------
package tasr_pkg;

    localparam int PWM_BITS      = 12;
    localparam int CNT_BITS      = PWM_BITS + 1;
    localparam int SPEED_BITS    = 7;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = PWM_BITS;
    localparam int NUM_AXES      = 3;
    localparam int AXIS_BITS     = $clog2(NUM_AXES);
    localparam int DIV_CNT_BITS  = $clog2(PWM_BITS);

    typedef logic [PWM_BITS-1:0]   pwm_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [SPEED_BITS-1:0] speed_t;

    localparam pwm_t   RESET_PWM   = pwm_t'(300);
    localparam pwm_t   PWM_MAX     = '1;
    localparam speed_t JUMP_SPEED  = speed_t'(100);
    localparam speed_t RESET_SPEED = speed_t'(50);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ARM_SPEED = 3'd0,
        CFG_X_LOW     = 3'd1,
        CFG_X_HIGH    = 3'd2,
        CFG_Y_LOW     = 3'd3,
        CFG_Y_HIGH    = 3'd4,
        CFG_Z_LOW     = 3'd5,
        CFG_Z_HIGH    = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BIG,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_RESID,
        ST_STEP,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic latch;
        logic find_big;
        logic div_load;
        logic div_step;
        logic axis_next;
        logic resid_init;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic changed;
        logic d_zero;
        logic div_done;
        logic last_axis;
    } status_t;

    typedef struct packed {
        pwm_t pos_x;
        pwm_t pos_y;
        pwm_t pos_z;
        logic servo_write;
        logic range_fault;
        logic at_goal;
    } result_t;

endpackage

/* rtl/tasr_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasr channels
// valid/ready channels for target ticks and position results
// ----------------------------------------------------------------------------
interface tasr_tgt_if
    import tasr_pkg::*;
();
    logic valid;
    logic ready;
    pwm_t target_x;
    pwm_t target_y;
    pwm_t target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

interface tasr_pos_if
    import tasr_pkg::*;
();
    logic valid;
    logic ready;
    pwm_t pos_x;
    pwm_t pos_y;
    pwm_t pos_z;
    logic servo_write;
    logic range_fault;
    logic at_goal;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output servo_write, output range_fault, output at_goal,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input servo_write, input range_fault, input at_goal,
                    output ready);
endinterface

/* rtl/three_axis_servo_ramp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_servo_ramp_core
// three-axis linear ramp of servo PWM counts with limit check
// ----------------------------------------------------------------------------
// Each target transaction yields one position transaction. A tick whose target
// equals the latched goal passes from acceptance through the check, step and
// push states into the output register; a tick with a new target first finds
// the largest distance and then passes through the shared restoring divider,
// which computes the three axis divisors one after another at one quotient bit
// per cycle (an axis with zero distance skips its divider run), before the
// residue setup, step and push states. One tick is processed at a time; the
// next target is taken once the previous result has moved into the output
// register, even if that result has not yet been taken. While an earlier
// result still waits in the output register, a finished tick holds in its last
// cycle until that result is taken. Configuration writes are applied at once
// and belong between transactions.
// ----------------------------------------------------------------------------
module three_axis_servo_ramp_core
    import tasr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    tasr_tgt_if.sink                 target,
    tasr_pos_if.source               position
);

    cmd_t    cmd;
    status_t status;
    result_t result;

    tasr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (target.valid),
        .in_ready  (target.ready),
        .out_valid (position.valid),
        .out_ready (position.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tasr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .target_x  (target.target_x),
        .target_y  (target.target_y),
        .target_z  (target.target_z),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign position.pos_x       = result.pos_x;
    assign position.pos_y       = result.pos_y;
    assign position.pos_z       = result.pos_z;
    assign position.servo_write = result.servo_write;
    assign position.range_fault = result.range_fault;
    assign position.at_goal     = result.at_goal;

    // one tick in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        target.valid && target.ready |=> !target.ready)
        else $error("target accepted while a tick is in flight");

    // no result appears in the cycle right after an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        target.valid && target.ready && !position.valid |=> !position.valid)
        else $error("result presented too early");

    // write and fault are exclusive
    a_write_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        position.valid |-> !(position.servo_write && position.range_fault))
        else $error("servo write and range fault both set");

endmodule

/* rtl/tasr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasr_datapath
// goal and position registers, serial divider, step residues and limit check
// ----------------------------------------------------------------------------
module tasr_datapath
    import tasr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  pwm_t                     target_x,
    input  pwm_t                     target_y,
    input  pwm_t                     target_z,
    input  cmd_t                     cmd,
    output status_t                  status,
    output result_t                  result
);

    speed_t                speed_reg;
    pwm_t                  lim_lo_reg [NUM_AXES];
    pwm_t                  lim_hi_reg [NUM_AXES];
    pwm_t                  goal_reg   [NUM_AXES];
    pwm_t                  cur_reg    [NUM_AXES];
    pwm_t                  div_reg    [NUM_AXES];
    pwm_t                  resid_reg  [NUM_AXES];
    cnt_t                  cnt_reg;
    logic                  jump_reg;
    logic [AXIS_BITS-1:0]  axis_reg;
    logic [DIV_CNT_BITS-1:0] bit_cnt_reg;

    pwm_t                  tgt_reg    [NUM_AXES];
    pwm_t                  dist_reg   [NUM_AXES];
    pwm_t                  big_reg;
    pwm_t                  rem_reg;
    pwm_t                  quo_reg;
    result_t               res_reg;
    result_t               out_reg;

    pwm_t                  dist_s     [NUM_AXES];
    pwm_t                  cur_next   [NUM_AXES];
    pwm_t                  resid_next [NUM_AXES];
    pwm_t                  eff_div    [NUM_AXES];
    pwm_t                  resid_inc  [NUM_AXES];
    cnt_t                  cnt_next;
    pwm_t                  big_s;
    pwm_t                  dvs;
    logic [PWM_BITS:0]     rem_shift;
    logic                  ge;
    pwm_t                  rem_next;
    pwm_t                  quo_next;
    logic                  changed_s;
    logic                  moving;
    logic                  moved;
    logic                  in_range;
    logic                  at_goal_s;
    logic                  div_last;

    // goal compare, distances and maximum
    always_comb
    begin
        changed_s = 1'b0;
        moving    = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (tgt_reg[a] != goal_reg[a])
                changed_s = 1'b1;
            if (goal_reg[a] != cur_reg[a])
                moving = 1'b1;
            dist_s[a] = (tgt_reg[a] > cur_reg[a]) ? tgt_reg[a] - cur_reg[a]
                                                  : cur_reg[a] - tgt_reg[a];
        end
        big_s = dist_reg[0];
        if (dist_reg[1] > big_s)
            big_s = dist_reg[1];
        if (dist_reg[2] > big_s)
            big_s = dist_reg[2];
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        dvs       = dist_reg[axis_reg];
        rem_shift = {rem_reg, quo_reg[PWM_BITS-1]};
        ge        = (rem_shift >= {1'b0, dvs});
        rem_next  = ge ? PWM_BITS'(rem_shift - {1'b0, dvs}) : rem_shift[PWM_BITS-1:0];
        quo_next  = {quo_reg[PWM_BITS-2:0], ge};
        div_last  = (bit_cnt_reg == DIV_CNT_BITS'(PWM_BITS - 1));
    end

    // one ramp step
    always_comb
    begin
        cnt_next  = cnt_reg + cnt_t'(1);
        moved     = 1'b0;
        in_range  = 1'b1;
        at_goal_s = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            eff_div[a]   = (div_reg[a] == '0) ? pwm_t'(1) : div_reg[a];
            resid_inc[a] = resid_reg[a] + pwm_t'(1);
            cur_next[a]  = cur_reg[a];
            if (moving && resid_reg[a] == '0)
            begin
                if (goal_reg[a] > cur_reg[a])
                begin
                    cur_next[a] = jump_reg ? goal_reg[a] : cur_reg[a] + pwm_t'(1);
                    moved       = 1'b1;
                end
                else if (goal_reg[a] < cur_reg[a])
                begin
                    cur_next[a] = jump_reg ? goal_reg[a] : cur_reg[a] - pwm_t'(1);
                    moved       = 1'b1;
                end
            end
            if (cnt_next == '0 || resid_inc[a] == eff_div[a])
                resid_next[a] = '0;
            else
                resid_next[a] = resid_inc[a];
            if (cur_next[a] > lim_hi_reg[a] || cur_next[a] < lim_lo_reg[a])
                in_range = 1'b0;
            if (cur_next[a] != goal_reg[a])
                at_goal_s = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= RESET_SPEED;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                lim_lo_reg[a] <= '0;
                lim_hi_reg[a] <= PWM_MAX;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ARM_SPEED: speed_reg     <= cfg_data[SPEED_BITS-1:0];
                CFG_X_LOW:     lim_lo_reg[0] <= cfg_data[PWM_BITS-1:0];
                CFG_X_HIGH:    lim_hi_reg[0] <= cfg_data[PWM_BITS-1:0];
                CFG_Y_LOW:     lim_lo_reg[1] <= cfg_data[PWM_BITS-1:0];
                CFG_Y_HIGH:    lim_hi_reg[1] <= cfg_data[PWM_BITS-1:0];
                CFG_Z_LOW:     lim_lo_reg[2] <= cfg_data[PWM_BITS-1:0];
                CFG_Z_HIGH:    lim_hi_reg[2] <= cfg_data[PWM_BITS-1:0];
                default:       speed_reg     <= speed_reg;
            endcase
        end
    end

    // ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                goal_reg[a]  <= RESET_PWM;
                cur_reg[a]   <= RESET_PWM;
                div_reg[a]   <= pwm_t'(1);
                resid_reg[a] <= '0;
            end
            cnt_reg     <= cnt_t'(1);
            jump_reg    <= 1'b0;
            axis_reg    <= '0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                    goal_reg[a] <= tgt_reg[a];
                jump_reg <= (speed_reg == JUMP_SPEED);
                cnt_reg  <= cnt_t'(1);
            end
            if (cmd.find_big)
                axis_reg <= '0;
            if (cmd.axis_next)
                axis_reg <= axis_reg + AXIS_BITS'(1);
            if (cmd.div_load)
                bit_cnt_reg <= '0;
            if (cmd.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + DIV_CNT_BITS'(1);
                if (div_last)
                    div_reg[axis_reg] <= quo_next;
            end
            if (cmd.resid_init)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                    resid_reg[a] <= (div_reg[a] <= pwm_t'(1)) ? pwm_t'(0) : pwm_t'(1);
            end
            if (cmd.step)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                    cur_reg[a] <= cur_next[a];
                if (moving)
                begin
                    cnt_reg <= cnt_next;
                    for (int a = 0; a < NUM_AXES; a++)
                        resid_reg[a] <= resid_next[a];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_reg[0] <= target_x;
            tgt_reg[1] <= target_y;
            tgt_reg[2] <= target_z;
        end
        if (cmd.latch)
        begin
            for (int a = 0; a < NUM_AXES; a++)
                dist_reg[a] <= dist_s[a];
        end
        if (cmd.find_big)
            big_reg <= big_s;
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= big_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.step)
        begin
            res_reg.pos_x       <= cur_next[0];
            res_reg.pos_y       <= cur_next[1];
            res_reg.pos_z       <= cur_next[2];
            res_reg.servo_write <= moved && in_range;
            res_reg.range_fault <= moved && !in_range;
            res_reg.at_goal     <= at_goal_s;
        end
        if (cmd.load_out)
            out_reg <= res_reg;
    end

    assign status.changed   = changed_s;
    assign status.d_zero    = (dvs == '0);
    assign status.div_done  = div_last;
    assign status.last_axis = (axis_reg == AXIS_BITS'(NUM_AXES - 1));
    assign result           = out_reg;

endmodule

/* rtl/tasr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasr_ctrl
// sequencer for goal latch, divisor computation, ramp step and result handoff
// ----------------------------------------------------------------------------
module tasr_ctrl
    import tasr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = status.changed ? ST_BIG : ST_STEP;
            ST_BIG:
                state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:
                if (!status.d_zero)
                    state_next = ST_DIV_RUN;
                else if (status.last_axis)
                    state_next = ST_RESID;
            ST_DIV_RUN:
                if (status.div_done)
                    state_next = status.last_axis ? ST_RESID : ST_DIV_LOAD;
            ST_RESID:
                state_next = ST_STEP;
            ST_STEP:
                state_next = ST_PUSH;
            ST_PUSH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_CHECK:
                cmd.latch = status.changed;
            ST_BIG:
                cmd.find_big = 1'b1;
            ST_DIV_LOAD:
            begin
                cmd.div_load  = !status.d_zero;
                cmd.axis_next = status.d_zero && !status.last_axis;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step  = 1'b1;
                cmd.axis_next = status.div_done && !status.last_axis;
            end
            ST_RESID:
                cmd.resid_init = 1'b1;
            ST_STEP:
                cmd.step = 1'b1;
            ST_PUSH:
                cmd.load_out = out_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
